// File: sv/fp32_multiply_truncating_macros.svh
// Assertion macros for the truncating single-precision multiplier.
// Used by the top level only.
`ifndef FP32_MULTIPLY_TRUNCATING_MACROS_SVH
`define FP32_MULTIPLY_TRUNCATING_MACROS_SVH

// assert that an antecedent implies a consequent in the same cycle
`define FMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// assert that an antecedent implies a consequent in the next cycle
`define FMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/fmt_pkg.sv
// Shared types and constants for the truncating fp32 multiplier.
// No dependencies.
`timescale 1ns / 1ps
package fmt_pkg;
  localparam logic [7:0] ExpBiasAdj     = 8'd130;
  localparam logic [8:0] UnderflowEdge  = 9'd127;
  localparam logic [8:0] UnderflowLimit = 9'd128;

  // stage 1 -> 2 word: unpacked operands
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [8:0]  esum;
    logic [23:0] sig_a;
    logic [23:0] sig_b;
  } unp_t;

  // stage 2 -> 3 word: raw product
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [8:0]  esum;
    logic [47:0] prod;
  } mul_t;

  // stage 3 -> 4 word: shift amounts
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [8:0]  esum;
    logic [5:0]  lz;
    logic [47:0] prod;
  } lzc_t;
endpackage

// File: sv/fmt_unpack.sv
// Stage 1: field split, hidden bits, exponent sum, zero detect.
// Depends on fmt_pkg.
`timescale 1ns / 1ps
module fmt_unpack (
  input  logic                clk_i,
  input  logic [31:0]         operand_a_i,
  input  logic [31:0]         operand_b_i,
  output fmt_pkg::unp_t       unp_q_o
);
  fmt_pkg::unp_t unp_d;
  logic [7:0] ea, eb;
  always_comb begin
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    unp_d.sign  = operand_a_i[31] ^ operand_b_i[31];
    unp_d.zero  = (operand_a_i[30:0] == 31'd0) || (operand_b_i[30:0] == 31'd0);
    unp_d.esum  = {1'b0, (ea == 8'd0) ? 8'd1 : ea} + {1'b0, (eb == 8'd0) ? 8'd1 : eb};
    unp_d.sig_a = {ea != 8'd0, operand_a_i[22:0]};
    unp_d.sig_b = {eb != 8'd0, operand_b_i[22:0]};
  end
  always_ff @(posedge clk_i) begin
    unp_q_o <= unp_d;
  end
endmodule

// File: sv/fmt_mul.sv
// Stages 2 and 3: 24x24 significand multiply, then leading-zero count.
// Depends on fmt_pkg.
`timescale 1ns / 1ps
module fmt_mul (
  input  logic          clk_i,
  input  fmt_pkg::unp_t unp_i,
  output fmt_pkg::lzc_t lzc_q_o
);
  fmt_pkg::mul_t mul_d, mul_q;
  fmt_pkg::lzc_t lzc_d;
  always_comb begin
    mul_d.sign = unp_i.sign;
    mul_d.zero = unp_i.zero;
    mul_d.esum = unp_i.esum;
    mul_d.prod = unp_i.sig_a * unp_i.sig_b;
  end
  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
  end
  // priority encoder; 48 is all zero
  always_comb begin
    lzc_d.sign = mul_q.sign;
    lzc_d.zero = mul_q.zero;
    lzc_d.esum = mul_q.esum;
    lzc_d.prod = mul_q.prod;
    lzc_d.lz   = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (mul_q.prod[i]) lzc_d.lz = 6'(47 - i);
    end
  end
  always_ff @(posedge clk_i) begin
    lzc_q_o <= lzc_d;
  end
endmodule

// File: sv/fmt_pack.sv
// Stage 4: normalise or denormalise, truncate, assemble result word.
// Depends on fmt_pkg.
`timescale 1ns / 1ps
module fmt_pack (
  input  logic          clk_i,
  input  fmt_pkg::lzc_t lzc_i,
  output logic [31:0]   product_q_o
);
  logic [47:0] normed, shifted;
  logic [8:0]  rsh;
  logic [7:0]  exp_n, exp_o;
  logic [22:0] frac_o;
  logic        under;
  logic [31:0] product_d;
  always_comb begin
    normed  = lzc_i.prod << lzc_i.lz;
    rsh     = (lzc_i.esum >= fmt_pkg::UnderflowEdge) ? 9'd0 :
              fmt_pkg::UnderflowEdge - lzc_i.esum;
    shifted = (rsh < 9'd48) ? (lzc_i.prod >> rsh) : 48'd0;
    exp_n   = lzc_i.esum[7:0] + fmt_pkg::ExpBiasAdj - {2'b00, lzc_i.lz};
    under   = lzc_i.esum < fmt_pkg::UnderflowLimit;
    // sum on the edge with a carried product just reaches the smallest normal
    if (lzc_i.esum == fmt_pkg::UnderflowEdge && lzc_i.prod[47]) exp_o = 8'd1;
    else if (under) exp_o = 8'd0;
    else exp_o = exp_n;
    frac_o = under ? shifted[46:24] : normed[46:24];
    product_d = lzc_i.zero ? {lzc_i.sign, 31'd0} : {lzc_i.sign, exp_o, frac_o};
  end
  always_ff @(posedge clk_i) begin
    product_q_o <= product_d;
  end
endmodule

// File: sv/fp32_multiply_truncating.sv
// Top level: four-stage truncating fp32 multiplier.
// Depends on fmt_pkg, fmt_unpack, fmt_mul, fmt_pack and the macros header.
//
//  channel | ports                           | handshake
//  input   | operand_a_i, operand_b_i        | start_i && !busy_o
//  result  | product_o                       | done_o strobe, one cycle
//
// done_o follows start_i through the valid shift register; one word accepted every cycle.
// busy_o is tied low: the pipeline never stalls and the receiver cannot.
// Reset clears only the valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "fp32_multiply_truncating_macros.svh"
module fp32_multiply_truncating (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] product_o
);
  fmt_pkg::unp_t unp_q;
  fmt_pkg::lzc_t lzc_q;
  logic [3:0] vld_q, vld_d;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 4'd0;
    end else begin
      vld_q <= vld_d;
    end
  end

  fmt_unpack u_unpack (.clk_i, .operand_a_i, .operand_b_i, .unp_q_o(unp_q));
  fmt_mul    u_mul    (.clk_i, .unp_i(unp_q), .lzc_q_o(lzc_q));
  fmt_pack   u_pack   (.clk_i, .lzc_i(lzc_q), .product_q_o(product_o));

  assign done_o = vld_q[3];

  `FMT_ASSERT_NEXT(a_vld_flow, clk_i, rst_ni, vld_q[2], done_o)
  `FMT_ASSERT_IMP(a_zero_sig, clk_i, rst_ni, vld_q[2] && lzc_q.zero, 1'b1)
  `FMT_ASSERT_NEXT(a_zero_out, clk_i, rst_ni, vld_q[2] && lzc_q.zero, product_o[30:0] == 31'd0)
endmodule

// File: sim/fp32_multiply_truncating_tb.sv
// Testbench for the truncating fp32 multiplier: directed and random operand pairs,
// products predicted in-bench and checked word by word. Depends on the RTL only.
`timescale 1ns / 1ps
module fp32_multiply_truncating_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] product_o;

  logic [31:0] product_q[$];
  int          n_fail = 0;
  int          n_sent = 0;
  int          n_seen = 0;
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  localparam int QuietLimit = 2000;

  fp32_multiply_truncating dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] fmul_trunc_predict(logic [31:0] a, logic [31:0] b);
    logic        sign;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [23:0] siga, sigb;
    logic [8:0]  esum;
    logic [47:0] prod, normed, shifted;
    int          lz, rsh;
    logic [7:0]  expo;
    logic [22:0] frac;
    sign = a[31] ^ b[31];
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0];  fb = b[22:0];
    if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0)) return {sign, 31'b0};
    siga = {ea != 0, fa};
    sigb = {eb != 0, fb};
    esum = 9'((ea == 0) ? 1 : ea) + 9'((eb == 0) ? 1 : eb);
    prod = siga * sigb;
    lz = 48;
    for (int i = 47; i >= 0; i--) if (prod[i]) begin lz = 47 - i; break; end
    normed = (lz < 48) ? prod << lz : '0;
    rsh = (esum >= 127) ? 0 : 127 - esum;
    shifted = (rsh < 48) ? prod >> rsh : '0;
    if (esum == 127 && prod[47]) expo = 8'd1;
    else if (esum < 128) expo = 8'd0;
    else expo = 8'(esum + 130 - lz);
    frac = (esum < 128) ? shifted[46:24] : normed[46:24];
    return {sign, expo, frac};
  endfunction

  // one word per call; random idle before it
  task automatic send_word(logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy_o);
    product_q.push_back(fmul_trunc_predict(a, b));
    n_sent++;
  endtask

  task automatic go_quiet();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (product_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    logic [31:0] want;
    if (done_o) begin
      n_seen++;
      if (product_q.size() == 0) begin
        $display("%0t: product 0x%08h with nothing expected", $time, product_o);
        n_fail++;
      end else begin
        want = product_q.pop_front();
        if (product_o !== want) begin
          $display("%0t: product expected 0x%08h actual 0x%08h", $time, want, product_o);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("fp32_multiply_truncating: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5, 0))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'($urandom_range(30, 0));
      2: v[30:23] = 8'($urandom_range(140, 110));
      3: v[30:23] = 8'd255;
      4: v[22:0] = $urandom_range(1) ? 23'd0 : 23'h7fffff;
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_word(32'h0000_0000, 32'h3f80_0000);
    send_word(32'h8000_0000, 32'h3f80_0000);
    send_word(32'h3f80_0000, 32'h0000_0000);
    send_word(32'h3f80_0000, 32'h3f80_0000);
    send_word(32'hbfc0_0000, 32'h4000_0000);
    send_word(32'hffff_ffff, 32'hffff_ffff);
    send_word(32'h7f7f_ffff, 32'h7f7f_ffff);  // exponent wraps
    send_word(32'h7f80_0000, 32'h3f80_0000);  // infinity passes through
    send_word(32'h7fc0_0001, 32'h4000_0000);  // NaN operand; exponent wraps to zero
    send_word(32'h0000_0001, 32'h0000_0001);  // long right shift
    send_word(32'h007f_ffff, 32'h3f80_0000);
    send_word(32'h3fff_ffff, 32'h007f_ffff);
    send_word(32'h1fff_ffff, 32'h1fff_ffff);  // sum 126
    send_word(32'h1fff_ffff, 32'h207f_ffff);  // sum 127, top bit set
    send_word(32'h1f80_0000, 32'h2000_0000);  // sum 127, top bit clear
    send_word(32'h2000_0000, 32'h2000_0000);  // sum 128
    send_word(32'h0080_0000, 32'h7f00_0000);
    send_word(32'h5555_5555, 32'haaaa_aaaa);
    send_word(32'haaaa_aaaa, 32'h5555_5555);
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    repeat (count) send_word(rand_float(), rand_float());
    idle_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    go_quiet();  // sender holds off until the pipe drains
    test_random(450, 0);
    test_random(450, 73);
    test_random(400, 24);
    test_random(450, 0);
    go_quiet();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d products: zeros, subnormals, underflow edge, wrap, NaN/inf.",
             n_seen);
    $display("Sent %0d words under several idle ratios.", n_sent);
    if (n_fail == 0 && product_q.size() == 0) begin
      $display("fp32_multiply_truncating: match");
    end else begin
      $display("fp32_multiply_truncating: mismatch");
    end
    $finish;
  end
endmodule
